### hw/rtl/bodd_pkg.sv
// Shared types and constants for the byte-offset delta decoder.
package bodd_pkg;

    localparam logic [7:0]  ESCAPE_BYTE = 8'h80;
    localparam logic [15:0] ESCAPE_WORD = 16'h8000;

    localparam int unsigned QUEUE_DEPTH = 4;

    // One decoded request handed from the parser to the accumulator.
    typedef struct packed {
        logic [31:0] delta;
        logic        clear;
        logic        truncated;
    } bodd_entry_t;

    // Queue status seen by the parser and the accumulator.
    typedef struct packed {
        logic full;
        logic empty;
    } bodd_queue_status_t;

endpackage

### hw/rtl/bodd_front.sv
// Token parser: turns raw bytes into deltas and truncation markers.
module bodd_front
    import bodd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // data_byte
    input  logic               s_tuser,   // blob_start
    input  logic               s_tlast,   // blob_end
    input  bodd_queue_status_t q_status,
    output logic               push,
    output bodd_entry_t        push_entry
);

    typedef enum logic [6:0] {
        PH_FIRST  = 7'b0000001,
        PH_W16_LO = 7'b0000010,
        PH_W16_HI = 7'b0000100,
        PH_W32_B0 = 7'b0001000,
        PH_W32_B1 = 7'b0010000,
        PH_W32_B2 = 7'b0100000,
        PH_W32_B3 = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [23:0] gathered_reg, gathered_next;
    logic        pending_clear_reg, pending_clear_next;
    logic        accept;
    logic        done;
    logic [31:0] delta;
    logic [15:0] word16;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign word16   = {s_tdata, gathered_reg[7:0]};

    // A blob start restarts token parsing before this byte is looked at.
    assign phase_cur = s_tuser ? PH_FIRST : phase_reg;

    always_comb begin
        phase_next    = phase_cur;
        gathered_next = gathered_reg;
        done          = 1'b0;
        delta         = '0;
        unique case (phase_cur)
            PH_W16_LO: begin
                gathered_next = {16'd0, s_tdata};
                phase_next    = PH_W16_HI;
            end
            PH_W16_HI: begin
                if (word16 == ESCAPE_WORD) begin
                    phase_next = PH_W32_B0;
                end else begin
                    delta = {{16{word16[15]}}, word16};
                    done  = 1'b1;
                end
            end
            PH_W32_B0: begin
                gathered_next = {16'd0, s_tdata};
                phase_next    = PH_W32_B1;
            end
            PH_W32_B1: begin
                gathered_next[15:8] = s_tdata;
                phase_next          = PH_W32_B2;
            end
            PH_W32_B2: begin
                gathered_next[23:16] = s_tdata;
                phase_next           = PH_W32_B3;
            end
            PH_W32_B3: begin
                delta = {s_tdata, gathered_reg};
                done  = 1'b1;
            end
            default: begin
                if (s_tdata == ESCAPE_BYTE) begin
                    phase_next = PH_W16_LO;
                end else begin
                    delta = {{24{s_tdata[7]}}, s_tdata};
                    done  = 1'b1;
                end
            end
        endcase
        if (done || s_tlast) begin
            phase_next = PH_FIRST;
        end
    end

    assign push                 = accept && (done || s_tlast);
    assign push_entry.delta     = done ? delta : 32'd0;
    assign push_entry.truncated = !done;
    // A start seen on a byte that gave no result still has to clear the sum.
    assign push_entry.clear     = pending_clear_reg || s_tuser;

    assign pending_clear_next = push ? 1'b0 : (pending_clear_reg || s_tuser);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_FIRST;
            pending_clear_reg <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            pending_clear_reg <= pending_clear_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            gathered_reg <= gathered_next;
        end
    end

endmodule

### hw/rtl/bodd_queue.sv
// Small first-in first-out queue of decoded requests.
module bodd_queue
    import bodd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  bodd_entry_t        push_entry,
    input  logic               pop,
    output bodd_entry_t        pop_entry,
    output bodd_queue_status_t status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);

    bodd_entry_t      slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == DEPTH_CNT);
    assign status.empty = (count_reg == '0);
    assign pop_entry    = slots_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

### hw/rtl/bodd_back.sv
// Accumulator and output register: adds each delta and presents the sum.
module bodd_back
    import bodd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  bodd_queue_status_t q_status,
    input  bodd_entry_t        pop_entry,
    output logic               pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata,   // pixel_value
    output logic               m_tuser    // truncated
);

    logic [31:0] sum_reg, sum_next;
    logic        valid_reg;
    logic        trunc_reg;

    // The sum only moves when a new result is loaded, so it doubles as the
    // output data register.
    assign pop      = !q_status.empty && (!valid_reg || m_tready);
    assign sum_next = (pop_entry.clear ? 32'd0 : sum_reg) + pop_entry.delta;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                sum_reg   <= sum_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            trunc_reg <= pop_entry.truncated;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = sum_reg;
    assign m_tuser  = trunc_reg;

endmodule

### hw/rtl/byte_offset_delta_decoder.sv
// Top level of the byte-offset delta decoder: parser, request queue, accumulator.
//
//   Channel  Direction  tdata              tuser       tlast
//   s_       in         data_byte [7:0]    blob_start  blob_end
//   m_       out        pixel_value [31:0] truncated   -
//
// One byte is taken per cycle while the queue is not full. A pixel passes through
// a queue slot, written when its last byte is accepted, and then the accumulator
// register, loaded when the back end pops that slot.
// The queue decouples the two sides, so s_tready drops only when it is full.
// Reset (aresetn low at a clock edge) empties the queue, clears the running sum
// and returns the parser to the start of a token.
module byte_offset_delta_decoder
    import bodd_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // blob_start
    input  logic        s_tlast,   // blob_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] pixel_value
    output logic        m_tuser    // truncated
);

    bodd_queue_status_t q_status;
    bodd_entry_t        push_entry, pop_entry;
    logic               push, pop;

    bodd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    bodd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .status     (q_status)
    );

    bodd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_status),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

### tb/sv/tb_byte_offset_delta_decoder.sv
// Self-checking testbench for the byte-offset delta decoder: directed and random blobs.
module tb_byte_offset_delta_decoder;
    import bodd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_BYTES = 450;
    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef enum logic [2:0] {
        PH_BYTE,
        PH_W16_LO,
        PH_W16_HI,
        PH_W32_B0,
        PH_W32_B1,
        PH_W32_B2,
        PH_W32_B3
    } token_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
        logic       last;
    } blob_byte_t;

    typedef struct packed {
        logic [31:0] pixel_value;
        logic        truncated;
    } pixel_t;

    // Tracks the decoder state and the pixels still owed by the block.
    class pixel_scoreboard;
        logic [31:0]  running_sum;
        token_phase_t phase;
        logic [23:0]  gathered;
        pixel_t       expected_pixels_q[$];
        int unsigned  mismatches;

        function new();
            running_sum = '0;
            phase       = PH_BYTE;
            gathered    = '0;
            mismatches  = 0;
        endfunction

        function void note_request(logic [7:0] b, logic first, logic last);
            logic [31:0] delta;
            logic [15:0] word;
            logic        done;
            delta = '0;
            done  = 1'b0;
            if (first) begin
                running_sum = '0;
                phase       = PH_BYTE;
                gathered    = '0;
            end
            case (phase)
                PH_W16_LO: begin
                    gathered = {16'h0, b};
                    phase    = PH_W16_HI;
                end
                PH_W16_HI: begin
                    word = {b, gathered[7:0]};
                    if (word == ESCAPE_WORD) begin
                        gathered = '0;
                        phase    = PH_W32_B0;
                    end else begin
                        delta = {{16{word[15]}}, word};
                        done  = 1'b1;
                    end
                end
                PH_W32_B0: begin
                    gathered = {16'h0, b};
                    phase    = PH_W32_B1;
                end
                PH_W32_B1: begin
                    gathered = {8'h0, b, gathered[7:0]};
                    phase    = PH_W32_B2;
                end
                PH_W32_B2: begin
                    gathered = {b, gathered[15:0]};
                    phase    = PH_W32_B3;
                end
                PH_W32_B3: begin
                    delta = {b, gathered};
                    done  = 1'b1;
                end
                default: begin
                    if (b == ESCAPE_BYTE) begin
                        phase = PH_W16_LO;
                    end else begin
                        delta = {{24{b[7]}}, b};
                        done  = 1'b1;
                    end
                end
            endcase
            if (done) begin
                running_sum = running_sum + delta;
                phase       = PH_BYTE;
                gathered    = '0;
                expected_pixels_q.push_back('{running_sum, 1'b0});
            end else if (last) begin
                // The unfinished token is dropped and the last sum is reported as truncated.
                phase    = PH_BYTE;
                gathered = '0;
                expected_pixels_q.push_back('{running_sum, 1'b1});
            end
        endfunction

        function void check_pixel(logic [31:0] pixel_value, logic truncated);
            pixel_t want;
            if (expected_pixels_q.size() == 0) begin
                $error("unexpected pixel: pixel_value %h truncated %b", pixel_value, truncated);
                mismatches++;
            end else begin
                want = expected_pixels_q.pop_front();
                if (pixel_value !== want.pixel_value) begin
                    $error("pixel_value: expected %h, actual %h", want.pixel_value, pixel_value);
                    mismatches++;
                end
                if (truncated !== want.truncated) begin
                    $error("truncated: expected %b, actual %b", want.truncated, truncated);
                    mismatches++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_pixels_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    pixel_scoreboard sb = new();
    blob_byte_t      byte_stream_q[$];
    int unsigned     idle_cycles = 0;
    logic [1:0]      stall_mode  = 2'd0;
    int unsigned     stall_left  = 0;
    logic [2:0]      stall_tick  = '0;

    byte_offset_delta_decoder i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                sb.check_pixel(m_tdata, m_tuser);
            end
            if (s_tvalid && s_tready) begin
                sb.note_request(s_tdata, s_tuser, s_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver switches between stall behaviours at random intervals.
    always @(posedge aclk) begin
        stall_tick <= stall_tick + 3'd1;
        if (stall_left == 0) begin
            stall_mode <= 2'($urandom_range(0, 3));
            stall_left <= $urandom_range(16, 200);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 3) != 0);
            2'd2: m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= (stall_tick == 3'd0);
        endcase
    end

    task automatic add_byte(input logic [7:0] data, input logic first = 1'b0,
                            input logic last = 1'b0);
        byte_stream_q.push_back('{data, first, last});
    endtask

    task automatic add_directed();
        add_byte(8'h7f, 1'b1);
        add_byte(8'h81);
        add_byte(8'h00);
        add_byte(8'hff);
        // Sixteen-bit escapes at both extremes.
        add_byte(ESCAPE_BYTE); add_byte(8'hff); add_byte(8'h7f);
        add_byte(ESCAPE_BYTE); add_byte(8'h01); add_byte(8'h80);
        // Thirty-two-bit escape with the most negative delta, so the sum wraps; the blob ends on it.
        add_byte(ESCAPE_BYTE); add_byte(8'h00); add_byte(8'h80);
        add_byte(8'h00); add_byte(8'h00); add_byte(8'h00); add_byte(8'h80, 1'b0, 1'b1);
        // No blob start: the sum carries over into the next blob.
        add_byte(8'h05);
        add_byte(ESCAPE_BYTE); add_byte(8'h00); add_byte(8'h80);
        // A new blob arrives in the middle of a token, then ends inside another one.
        add_byte(ESCAPE_BYTE, 1'b1);
        add_byte(8'h34, 1'b0, 1'b1);
        add_byte(ESCAPE_BYTE, 1'b1, 1'b1);
        add_byte(8'h42, 1'b1, 1'b1);
    endtask

    task automatic add_random_blob();
        logic [7:0]  blob_q[$];
        logic [31:0] word;
        int unsigned n_tok;
        int unsigned kind;
        int unsigned last_len;
        int unsigned drop;
        if ($urandom_range(0, 9) == 0) begin
            // Noise: raw bytes with escape-heavy content and scattered blob flags.
            repeat ($urandom_range(1, 12)) begin
                kind = $urandom_range(0, 7);
                word = $urandom;
                if (kind < 2) begin
                    word[7:0] = ESCAPE_BYTE;
                end else if (kind == 2) begin
                    word[7:0] = 8'h00;
                end
                add_byte(word[7:0], ($urandom_range(0, 7) == 0), ($urandom_range(0, 7) == 0));
            end
        end else begin
            n_tok    = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
            last_len = 0;
            repeat (n_tok) begin
                kind = $urandom_range(0, 99);
                word = $urandom;
                if (kind < 50) begin
                    while (word[7:0] == ESCAPE_BYTE) word[7:0] = 8'($urandom);
                    blob_q.push_back(word[7:0]);
                    last_len = 1;
                end else if (kind < 80) begin
                    while (word[15:0] == ESCAPE_WORD) word[15:0] = 16'($urandom);
                    blob_q.push_back(ESCAPE_BYTE);
                    blob_q.push_back(word[7:0]);
                    blob_q.push_back(word[15:8]);
                    last_len = 3;
                end else begin
                    if (kind >= 95) begin
                        word = (kind[0]) ? 32'h7fff_ffff : 32'h8000_0000;
                    end
                    blob_q.push_back(ESCAPE_BYTE);
                    blob_q.push_back(ESCAPE_WORD[7:0]);
                    blob_q.push_back(ESCAPE_WORD[15:8]);
                    blob_q.push_back(word[7:0]);
                    blob_q.push_back(word[15:8]);
                    blob_q.push_back(word[23:16]);
                    blob_q.push_back(word[31:24]);
                    last_len = 7;
                end
            end
            // Sometimes cut the final token short so the blob ends inside it.
            if (last_len > 1 && $urandom_range(0, 6) == 0) begin
                drop = $urandom_range(1, last_len - 1);
                repeat (drop) void'(blob_q.pop_back());
            end
            foreach (blob_q[i]) begin
                add_byte(blob_q[i],
                         (i == 0) && ($urandom_range(0, 9) != 0),
                         (i == blob_q.size() - 1) && ($urandom_range(0, 9) != 0));
            end
        end
    endtask

    task automatic stream_bytes();
        int unsigned idx;
        int unsigned burst;
        int unsigned gap;
        idx = 0;
        while (idx < byte_stream_q.size()) begin
            burst = $urandom_range(1, 24);
            while (burst != 0 && idx < byte_stream_q.size()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= byte_stream_q[idx].data;
                s_tuser  <= byte_stream_q[idx].first;
                s_tlast  <= byte_stream_q[idx].last;
                @(posedge aclk);
                while (!s_tready) @(posedge aclk);
                idx++;
                burst--;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int unsigned directed_len;
        add_directed();
        directed_len = byte_stream_q.size();
        while (byte_stream_q.size() < directed_len + RANDOM_BYTES) add_random_blob();

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        stream_bytes();

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
